// ----- rtl/bdnm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdnm_pkg: shared types and constants of the descriptor matcher
// Field structs, action and register codes, sizes and the 64-bit popcount.
// ----------------------------------------------------------------------------
package bdnm_pkg;

  localparam int MAX_REFS   = 1024;
  localparam int DESC_WORDS = 4;
  localparam int WORD_W     = 64;
  localparam int ENTRY_W    = $clog2(MAX_REFS);
  localparam int COUNT_W    = 11;
  localparam int WSEL_W     = 2;
  localparam int DIST_W     = 9;
  localparam int POP_W      = 7;
  localparam int COORD_W    = 16;
  localparam int POINT_W    = 4 * COORD_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [1:0] ACT_LOAD_WORD  = 2'd0;
  localparam logic [1:0] ACT_LOAD_POINT = 2'd1;
  localparam logic [1:0] ACT_QUERY      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESH = 2'd2;

  localparam logic [DIST_W-1:0]  SEARCH_LIMIT_RST = 9'd128;
  localparam logic [DIST_W-1:0]  MATCH_THRESH_RST = 9'd80;
  localparam logic [COUNT_W-1:0] MAX_REFS_C       = COUNT_W'(MAX_REFS);
  localparam logic [WSEL_W-1:0]  LAST_WORD        = WSEL_W'(DESC_WORDS - 1);

  typedef struct packed {
    logic [1:0]                action;
    logic [ENTRY_W-1:0]        entry_index;
    logic [WSEL_W-1:0]         word_index;
    logic [WORD_W-1:0]         word_data;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] normal_y;
  } item_t;

  typedef struct packed {
    logic                      matched;
    logic [ENTRY_W-1:0]        best_index;
    logic [DIST_W-1:0]         best_distance;
    logic [COORD_W-1:0]        match_pixel_x;
    logic [COORD_W-1:0]        match_pixel_y;
    logic signed [COORD_W-1:0] match_normal_x;
    logic signed [COORD_W-1:0] match_normal_y;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic issue;
    logic fetch;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic query_end;
    logic issue_done;
    logic pipe_busy;
  } status_t;

  // SWAR popcount: pair, nibble, byte sums, then fold the bytes
  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] f;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    f = e + (e >> 32);
    return f[POP_W-1:0];
  endfunction

endpackage

// ----- rtl/bdnm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdnm_ctrl: scan sequencer
// Runs a query through scan, pipeline drain, point fetch and result emit.
// ----------------------------------------------------------------------------
module bdnm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  bdnm_pkg::status_t  status,
  output bdnm_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FETCH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (status.query_end) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.issue_done) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.pipe_busy) state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EMIT);
    end
  end

  assign busy = (state != S_IDLE);

  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EMIT))
    else $error("result strobe without emit");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (status.query_end && state == S_IDLE) |=> busy)
    else $error("query end did not start a scan");

endmodule

// ----- rtl/bdnm_datapath.sv -----
// ----------------------------------------------------------------------------
// bdnm_datapath: reference store, Hamming pipeline and best tracking
// Four word memories read side by side, popcount stage, sum and compare stage.
// ----------------------------------------------------------------------------
module bdnm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  bdnm_pkg::item_t                     item,
  input  logic                                cfg_we,
  input  logic [bdnm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdnm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  bdnm_pkg::cmd_t                      cmd,
  output bdnm_pkg::status_t                   status,
  output bdnm_pkg::result_t                   result
);

  // configuration
  logic [bdnm_pkg::COUNT_W-1:0] ref_count;
  logic [bdnm_pkg::DIST_W-1:0]  search_limit;
  logic [bdnm_pkg::DIST_W-1:0]  match_thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count    <= '0;
      search_limit <= bdnm_pkg::SEARCH_LIMIT_RST;
      match_thresh <= bdnm_pkg::MATCH_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdnm_pkg::CFG_REF_COUNT:    ref_count    <= cfg_data;
        bdnm_pkg::CFG_SEARCH_LIMIT: search_limit <= cfg_data[bdnm_pkg::DIST_W-1:0];
        bdnm_pkg::CFG_MATCH_THRESH: match_thresh <= cfg_data[bdnm_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  logic load_word;
  logic load_point;
  logic query_word;

  assign load_word  = accept && (item.action == bdnm_pkg::ACT_LOAD_WORD);
  assign load_point = accept && (item.action == bdnm_pkg::ACT_LOAD_POINT);
  assign query_word = accept && (item.action == bdnm_pkg::ACT_QUERY);
  assign status.query_end = query_word && (item.word_index == bdnm_pkg::LAST_WORD);

  // query descriptor
  logic [bdnm_pkg::WORD_W-1:0] query [bdnm_pkg::DESC_WORDS];

  always_ff @(posedge clk) begin
    if (query_word) query[item.word_index] <= item.word_data;
  end

  // scan address
  logic [bdnm_pkg::COUNT_W-1:0] addr;
  logic [bdnm_pkg::COUNT_W-1:0] scan_count;
  logic                         issue;

  assign status.issue_done = (addr == scan_count);
  assign issue             = cmd.issue && !status.issue_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      scan_count <= '0;
    end else if (status.query_end) begin
      addr       <= '0;
      scan_count <= (ref_count > bdnm_pkg::MAX_REFS_C) ? bdnm_pkg::MAX_REFS_C : ref_count;
    end else if (issue) begin
      addr <= addr + 1'b1;
    end
  end

  // reference word memories, one per descriptor word
  logic [bdnm_pkg::WORD_W-1:0] ref_rd [bdnm_pkg::DESC_WORDS];

  for (genvar w = 0; w < bdnm_pkg::DESC_WORDS; w++) begin : g_word
    logic [bdnm_pkg::WORD_W-1:0] mem [bdnm_pkg::MAX_REFS];

    always_ff @(posedge clk) begin
      if (load_word && (item.word_index == bdnm_pkg::WSEL_W'(w)))
        mem[item.entry_index] <= item.word_data;
      if (issue) ref_rd[w] <= mem[addr[bdnm_pkg::ENTRY_W-1:0]];
    end
  end

  // point memory: {normal_y, normal_x, pixel_y, pixel_x}
  logic [bdnm_pkg::POINT_W-1:0] point_mem [bdnm_pkg::MAX_REFS];
  logic [bdnm_pkg::POINT_W-1:0] point_rd;
  logic [bdnm_pkg::ENTRY_W-1:0] best_idx;

  always_ff @(posedge clk) begin
    if (load_point)
      point_mem[item.entry_index] <= {item.normal_y, item.normal_x,
                                      item.pixel_y, item.pixel_x};
    if (cmd.fetch) point_rd <= point_mem[best_idx];
  end

  // pipeline: read -> popcount -> sum and compare
  logic                         v1;
  logic                         v2;
  logic [bdnm_pkg::ENTRY_W-1:0] idx1;
  logic [bdnm_pkg::ENTRY_W-1:0] idx2;
  logic [bdnm_pkg::POP_W-1:0]   cnt [bdnm_pkg::DESC_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= addr[bdnm_pkg::ENTRY_W-1:0];
    idx2 <= idx1;
    for (int w = 0; w < bdnm_pkg::DESC_WORDS; w++)
      cnt[w] <= bdnm_pkg::pop64(query[w] ^ ref_rd[w]);
  end

  assign status.pipe_busy = v1 || v2;

  logic [bdnm_pkg::DIST_W-1:0] hamming;
  logic [bdnm_pkg::DIST_W-1:0] best;
  logic                        found;

  always_comb begin
    hamming = '0;
    for (int w = 0; w < bdnm_pkg::DESC_WORDS; w++)
      hamming = hamming + bdnm_pkg::DIST_W'(cnt[w]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      best     <= '0;
      best_idx <= '0;
    end else if (status.query_end) begin
      found    <= 1'b0;
      best     <= search_limit;
      best_idx <= '0;
    end else if (v2 && (hamming < best)) begin
      found    <= 1'b1;
      best     <= hamming;
      best_idx <= idx2;
    end
  end

  // result register
  logic matched;

  assign matched = found && (best < match_thresh);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.matched        <= matched;
      result.best_index     <= best_idx;
      result.best_distance  <= best;
      result.match_pixel_x  <= matched ? point_rd[0*bdnm_pkg::COORD_W +: bdnm_pkg::COORD_W]
                                       : '0;
      result.match_pixel_y  <= matched ? point_rd[1*bdnm_pkg::COORD_W +: bdnm_pkg::COORD_W]
                                       : '0;
      result.match_normal_x <= matched ? point_rd[2*bdnm_pkg::COORD_W +: bdnm_pkg::COORD_W]
                                       : '0;
      result.match_normal_y <= matched ? point_rd[3*bdnm_pkg::COORD_W +: bdnm_pkg::COORD_W]
                                       : '0;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ({1'b0, idx2} < scan_count))
    else $error("scanned entry beyond reference count");

  a_issue_fills_pipe: assert property (@(posedge clk) disable iff (rst)
    issue |=> v1)
    else $error("issued read lost in pipeline");

  a_best_never_rises: assert property (@(posedge clk) disable iff (rst)
    (v2 && !status.query_end) |=> (best <= $past(best)))
    else $error("best distance increased during scan");

endmodule

// ----- rtl/brief_descriptor_nearest_match.sv -----
// ----------------------------------------------------------------------------
// brief_descriptor_nearest_match: brute-force Hamming matcher, 256-bit BRIEF
// Loads reference descriptors and points, then scans them for each query.
// ----------------------------------------------------------------------------
// Load actions and non-final query words are accepted with busy staying
// low. The final query word raises busy and starts a scan that reads one
// reference per cycle from the four word memories. For the n references
// scanned (reference_count, capped at 1024) the block issues one read per
// reference, leaves the scan, lets the popcount and compare pipeline drain,
// reads the point memory, registers the result and then raises the result
// strobe. busy drops in the strobe cycle, so the next beat can be taken at
// the edge that ends it.
// done is high for exactly one cycle with result valid; the receiver cannot
// stall it, and result holds until the next query. Configuration writes are
// always ready and belong in idle periods.
module brief_descriptor_nearest_match (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  bdnm_pkg::item_t                  item,
  output logic                             done,
  output bdnm_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdnm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bdnm_pkg::cmd_t    cmd;
  bdnm_pkg::status_t status;
  logic              accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  bdnm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bdnm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// ----- bench/tb_brief_descriptor_nearest_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brief_descriptor_nearest_match: self-checking bench for the matcher
// Loads reference descriptors and points, runs queries under many limit and
// count settings, and checks every scan result against a local predictor of
// the Hamming nearest-reference search.
// ----------------------------------------------------------------------------
module tb_brief_descriptor_nearest_match;
  import bdnm_pkg::*;

  localparam logic [1:0]           ACT_NONE       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
  localparam int                   WATCHDOG_LIMIT = 5000;
  localparam int                   IDLE_PAD       = 10;
  localparam int                   LATENCY_PAD    = 1040;
  localparam int                   RANDOM_BEATS   = 230;
  localparam int                   BANK_SIZE      = 64;

  typedef logic [DESC_WORDS*WORD_W-1:0] desc_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  item_t                 item      = '0;
  logic                  done;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  brief_descriptor_nearest_match dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [WORD_W-1:0]         ref_desc [MAX_REFS][DESC_WORDS];
  logic [COORD_W-1:0]        ref_px [MAX_REFS];
  logic [COORD_W-1:0]        ref_py [MAX_REFS];
  logic signed [COORD_W-1:0] ref_nx [MAX_REFS];
  logic signed [COORD_W-1:0] ref_ny [MAX_REFS];
  logic [WORD_W-1:0]         query_desc [DESC_WORDS];
  logic [COUNT_W-1:0]        scan_count  = '0;
  logic [DIST_W-1:0]         dist_limit  = SEARCH_LIMIT_RST;
  logic [DIST_W-1:0]         match_limit = MATCH_THRESH_RST;

  result_t expected_matches [$];
  result_t oldest_match;

  int    mismatches   = 0;
  int    beats_sent   = 0;
  int    reg_writes   = 0;
  int    results_seen = 0;
  int    matches_seen = 0;
  int    idle_cycles  = 0;
  bit    back_to_back = 1'b0;
  desc_t probe;

  function automatic result_t nearest_reference();
    result_t     r;
    int unsigned n;
    int unsigned hamming;
    int unsigned best;
    int unsigned best_at;
    bit          found;
    n       = (scan_count > MAX_REFS) ? MAX_REFS : scan_count;
    best    = dist_limit;
    best_at = 0;
    found   = 1'b0;
    for (int i = 0; i < n; i++) begin
      hamming = 0;
      for (int w = 0; w < DESC_WORDS; w++)
        hamming += $countones(query_desc[w] ^ ref_desc[i][w]);
      if (hamming < best) begin
        best    = hamming;
        best_at = i;
        found   = 1'b1;
      end
    end
    r               = '0;
    r.matched       = found && (best < match_limit);
    r.best_index    = ENTRY_W'(best_at);
    r.best_distance = DIST_W'(best);
    if (r.matched) begin
      r.match_pixel_x  = ref_px[best_at];
      r.match_pixel_y  = ref_py[best_at];
      r.match_normal_x = ref_nx[best_at];
      r.match_normal_y = ref_ny[best_at];
    end
    return r;
  endfunction

  function automatic void apply_beat(item_t b);
    case (b.action)
      ACT_LOAD_WORD: begin
        ref_desc[b.entry_index][b.word_index] = b.word_data;
      end
      ACT_LOAD_POINT: begin
        ref_px[b.entry_index] = b.pixel_x;
        ref_py[b.entry_index] = b.pixel_y;
        ref_nx[b.entry_index] = b.normal_x;
        ref_ny[b.entry_index] = b.normal_y;
      end
      ACT_QUERY: begin
        query_desc[b.word_index] = b.word_data;
        if (b.word_index == LAST_WORD)
          expected_matches.insert(expected_matches.size(), nearest_reference());
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic desc_t rand_desc();
    desc_t d;
    for (int w = 0; w < DESC_WORDS; w++)
      d[w*WORD_W +: WORD_W] = rand_word();
    return d;
  endfunction

  function automatic desc_t entry_desc(int e);
    desc_t d;
    for (int w = 0; w < DESC_WORDS; w++)
      d[w*WORD_W +: WORD_W] = ref_desc[e][w];
    return d;
  endfunction

  // flip k random bits; repeats may cancel, so distance is at most k
  function automatic desc_t perturb(desc_t d, int k);
    repeat (k) d[$urandom_range(0, DESC_WORDS*WORD_W-1)] ^= 1'b1;
    return d;
  endfunction

  // unused fields of a beat carry random noise
  function automatic item_t make_beat(logic [1:0] act, int e, int w, logic [WORD_W-1:0] data);
    item_t b;
    b.action      = act;
    b.entry_index = ENTRY_W'(e);
    b.word_index  = WSEL_W'(w);
    b.word_data   = data;
    b.pixel_x     = COORD_W'($urandom);
    b.pixel_y     = COORD_W'($urandom);
    b.normal_x    = COORD_W'($urandom);
    b.normal_y    = COORD_W'($urandom);
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (back_to_back || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // every task starts and ends on a falling edge
  task automatic send_beat(input item_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk); while (busy);
    apply_beat(beat);
    if (beat.action != ACT_NONE)
      beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_point(int e, logic [15:0] px, logic [15:0] py, logic [15:0] nx,
                            logic [15:0] ny);
    item_t b;
    b          = make_beat(ACT_LOAD_POINT, e, $urandom_range(0, 3), rand_word());
    b.pixel_x  = px;
    b.pixel_y  = py;
    b.normal_x = nx;
    b.normal_y = ny;
    send_beat(b);
  endtask

  task automatic load_entry(int e, desc_t d);
    for (int w = 0; w < DESC_WORDS; w++)
      send_beat(make_beat(ACT_LOAD_WORD, e, w, d[w*WORD_W +: WORD_W]));
    send_point(e, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // words 0..2 in a rotated order, the last word closes the query
  task automatic send_query(desc_t q);
    int first;
    int w;
    first = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      w = (first + i) % 3;
      send_beat(make_beat(ACT_QUERY, $urandom_range(0, MAX_REFS-1), w,
                          q[w*WORD_W +: WORD_W]));
    end
    send_beat(make_beat(ACT_QUERY, $urandom_range(0, MAX_REFS-1), LAST_WORD,
                        q[LAST_WORD*WORD_W +: WORD_W]));
  endtask

  task automatic send_last_word(logic [WORD_W-1:0] data);
    send_beat(make_beat(ACT_QUERY, $urandom_range(0, MAX_REFS-1), LAST_WORD, data));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REF_COUNT:    scan_count  = data;
      CFG_SEARCH_LIMIT: dist_limit  = data[DIST_W-1:0];
      CFG_MATCH_THRESH: match_limit = data[DIST_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // block is idle once all scans have reported and loads have drained
  task automatic settle(int pad);
    start <= 1'b0;
    while (expected_matches.size() > 0) @(negedge clk);
    repeat (pad) @(negedge clk);
  endtask

  // reset limits apply; nothing loaded, so the scan is empty
  task automatic test_empty_scan();
    probe = rand_desc();
    send_query(probe);
  endtask

  // entry 2 duplicates entry 1, so the earlier one must win the tie
  task automatic test_first_closest();
    for (int w = 0; w < DESC_WORDS; w++)
      send_beat(make_beat(ACT_LOAD_WORD, 0, w, '1));
    send_point(0, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    for (int w = 0; w < DESC_WORDS; w++)
      send_beat(make_beat(ACT_LOAD_WORD, 1, w, probe[w*WORD_W +: WORD_W]));
    send_point(1, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
    load_entry(2, probe);
    settle(IDLE_PAD);
    write_reg(CFG_REF_COUNT, 3);
    send_last_word(probe[LAST_WORD*WORD_W +: WORD_W]);
    send_last_word(~probe[LAST_WORD*WORD_W +: WORD_W]);
  endtask

  task automatic test_distance_limits();
    settle(IDLE_PAD);
    write_reg(CFG_MATCH_THRESH, 0);
    send_last_word(probe[LAST_WORD*WORD_W +: WORD_W]);
    settle(IDLE_PAD);
    write_reg(CFG_SEARCH_LIMIT, 0);
    write_reg(CFG_MATCH_THRESH, 257);
    send_last_word(probe[LAST_WORD*WORD_W +: WORD_W]);
    send_beat(make_beat(ACT_NONE, $urandom_range(0, MAX_REFS-1), LAST_WORD, '1));
    settle(IDLE_PAD);
    // all-zero query against the all-ones entry: distance 256 under limit 257
    write_reg(CFG_REF_COUNT, 1);
    write_reg(CFG_SEARCH_LIMIT, 257);
    send_query('0);
  endtask

  // fills a bank of entries back to back, then scans all of it
  task automatic test_bank_scan();
    back_to_back = 1'b1;
    for (int i = 3; i < BANK_SIZE; i++) begin
      if ($urandom_range(0, 15) == 0)
        load_entry(i, entry_desc($urandom_range(0, i-1)));
      else
        load_entry(i, rand_desc());
    end
    back_to_back = 1'b0;
    settle(IDLE_PAD);
    write_reg(CFG_REF_COUNT, COUNT_W'(BANK_SIZE));
    write_reg(CFG_MATCH_THRESH, 257);
    send_query(perturb(entry_desc(BANK_SIZE-1), 3));
    send_query(perturb(entry_desc($urandom_range(0, BANK_SIZE-1)), 40));
    settle(IDLE_PAD);
    write_reg(CFG_SEARCH_LIMIT, SEARCH_LIMIT_RST);
    write_reg(CFG_MATCH_THRESH, MATCH_THRESH_RST);
    send_query(perturb(entry_desc($urandom_range(BANK_SIZE/2, BANK_SIZE-1)), 6));
    send_query(perturb(entry_desc($urandom_range(0, BANK_SIZE-1)), 70));
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_limit(int lo);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
    if (r < 22)
      return (r < 18) ? 0 : 257;
    return CFG_DATA_W'($urandom_range(lo, 257));
  endfunction

  task automatic random_phase();
    int r;
    int n;
    int e;
    settle(IDLE_PAD);
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      if (r < 10)      write_reg(CFG_REF_COUNT, 0);
      else if (r < 85) write_reg(CFG_REF_COUNT, COUNT_W'($urandom_range(1, 48)));
      else             write_reg(CFG_REF_COUNT, COUNT_W'($urandom_range(49, BANK_SIZE)));
    end
    if ($urandom_range(0, 1))
      write_reg(CFG_SEARCH_LIMIT, pick_limit(60));
    if ($urandom_range(0, 1))
      write_reg(CFG_MATCH_THRESH, pick_limit(20));
    if ($urandom_range(0, 15) == 0)
      write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    back_to_back = ($urandom_range(0, 3) == 0);
    n = (scan_count == 0) ? BANK_SIZE : int'(scan_count);
    repeat ($urandom_range(6, 20)) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        e = $urandom_range(0, n-1);
        case ($urandom_range(0, 3))
          0:       send_query(perturb(entry_desc(e), $urandom_range(0, 6)));
          1, 2:    send_query(perturb(entry_desc(e), $urandom_range(7, 90)));
          default: send_query(perturb(entry_desc(e), $urandom_range(91, 256)));
        endcase
      end else if (r < 62) begin
        // lone or out-of-sequence query word over the held query
        send_beat(make_beat(ACT_QUERY, $urandom_range(0, MAX_REFS-1),
                            $urandom_range(0, 3), rand_word()));
      end else if (r < 72) begin
        e = ($urandom_range(0, 9) < 7) ? $urandom_range(0, BANK_SIZE-1)
                                       : $urandom_range(0, MAX_REFS-1);
        send_beat(make_beat(ACT_LOAD_WORD, e, $urandom_range(0, 3), rand_word()));
      end else if (r < 80) begin
        // duplicate descriptors set up ties for the first-closest rule
        load_entry($urandom_range(0, BANK_SIZE-1), entry_desc($urandom_range(0, BANK_SIZE-1)));
      end else if (r < 92) begin
        send_point($urandom_range(0, MAX_REFS-1), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
      end else begin
        send_beat(make_beat(ACT_NONE, $urandom_range(0, MAX_REFS-1), $urandom_range(0, 3),
                            rand_word()));
      end
    end
    back_to_back = 1'b0;
  endtask

  task automatic test_random_traffic();
    int goal;
    goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < goal)
      random_phase();
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_matches.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %p", $time, result);
        mismatches++;
      end else begin
        oldest_match = expected_matches.pop_front();
        if (oldest_match.matched)
          matches_seen++;
        check_field("matched",        oldest_match.matched,        result.matched);
        check_field("best_index",     oldest_match.best_index,     result.best_index);
        check_field("best_distance",  oldest_match.best_distance,  result.best_distance);
        check_field("match_pixel_x",  oldest_match.match_pixel_x,  result.match_pixel_x);
        check_field("match_pixel_y",  oldest_match.match_pixel_y,  result.match_pixel_y);
        check_field("match_normal_x", oldest_match.match_normal_x, result.match_normal_x);
        check_field("match_normal_y", oldest_match.match_normal_y, result.match_normal_y);
      end
    end
  end

  // watchdog: cycles with no beat, result or register write
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_scan();
    test_first_closest();
    test_distance_limits();
    test_bank_scan();
    test_random_traffic();
    settle(LATENCY_PAD);
    if (expected_matches.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_matches.size());
      mismatches++;
    end
    $display("Sent %0d beats and %0d register writes; checked %0d scan results, %0d matched.",
             beats_sent, reg_writes, results_seen, matches_seen);
    $display("Scans ranged from empty to a full %0d-entry bank, limits from 0 to 511.",
             BANK_SIZE);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
